// File: rtl/bpa_pkg.sv
package bpa_pkg;

    // Region geometry
    localparam int NUM_PAGES  = 64;
    localparam int PAGE_BYTES = 64;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    // Field widths
    localparam int ADDR_W       = 32;
    localparam int SIZE_W       = 13;
    localparam int PAGE_COUNT_W = 7;

    // Page index, chain link (index or end mark) and page counters
    localparam int IDX_W  = $clog2(NUM_PAGES);
    localparam int LINK_W = $clog2(NUM_PAGES + 1);
    localparam int NEED_W = SIZE_W + 1 - PAGE_SHIFT;

    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NUM_PAGES);

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_BADADDR = 2'd3
    } status_t;

    typedef struct packed {
        req_type_t          req_type;
        logic [SIZE_W-1:0]  size_bytes;
        logic [ADDR_W-1:0]  free_address;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic [ADDR_W-1:0]        result_address;
        logic [PAGE_COUNT_W-1:0]  page_count;
    } rsp_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [LINK_W-1:0]  wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } mem_req_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_WALK,
        S_FINISH
    } state_t;

endpackage

// File: rtl/bpa_chain_mem.sv
module bpa_chain_mem (
    input  logic                          clk,
    input  bpa_pkg::mem_req_t             mem_req,
    output logic [bpa_pkg::LINK_W-1:0]    mem_rdata
);
    import bpa_pkg::*;

    logic [LINK_W-1:0] link_mem [NUM_PAGES];
    logic [LINK_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            link_mem[mem_req.waddr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rdata_reg <= link_mem[mem_req.raddr];
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

// File: rtl/bpa_engine.sv
module bpa_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  bpa_pkg::req_t                 req,
    input  logic [bpa_pkg::ADDR_W-1:0]    base_address,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bpa_pkg::rsp_t                 res,
    output bpa_pkg::mem_req_t             mem_req,
    input  logic [bpa_pkg::LINK_W-1:0]    mem_rdata
);
    import bpa_pkg::*;

    state_t               state_reg, state_next;
    logic [NUM_PAGES-1:0] used_map_reg, used_map_next;
    logic [LINK_W-1:0]    free_pages_reg, free_pages_next;
    logic [NEED_W-1:0]    need_reg, need_next;
    logic [LINK_W-1:0]    scan_reg, scan_next;
    logic [LINK_W-1:0]    got_reg, got_next;
    logic [IDX_W-1:0]     prev_reg, prev_next;
    logic [IDX_W-1:0]     first_reg, first_next;
    logic [LINK_W-1:0]    cur_reg, cur_next;
    logic                 walk_first_reg, walk_first_next;
    logic [LINK_W-1:0]    steps_reg, steps_next;
    logic [LINK_W-1:0]    cnt_reg, cnt_next;
    rsp_t                 res_reg, res_next;

    logic                 req_accept;
    logic [NEED_W-1:0]    need;
    logic [ADDR_W-1:0]    offset;
    logic                 addr_bad;
    logic [LINK_W-1:0]    cur;
    logic [LINK_W:0]      free_sum;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign res_valid  = (state_reg == S_FINISH);
    assign res        = res_reg;

    assign need   = NEED_W'((SIZE_W + 1)'(req.size_bytes) + (SIZE_W + 1)'(PAGE_BYTES - 1)
                    >> PAGE_SHIFT);
    assign offset = req.free_address - base_address;
    assign cur    = walk_first_reg ? cur_reg : mem_rdata;

    always_comb
    begin
        addr_bad = 1'b0;
        if (offset[PAGE_SHIFT-1:0] != '0)
        begin
            addr_bad = 1'b1;
        end
        else if (offset[ADDR_W-1:PAGE_SHIFT] >= (ADDR_W - PAGE_SHIFT)'(NUM_PAGES))
        begin
            addr_bad = 1'b1;
        end
        else if (!used_map_reg[offset[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT]])
        begin
            addr_bad = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_map_reg   <= '0;
            free_pages_reg <= LINK_W'(NUM_PAGES);
        end
        else
        begin
            state_reg      <= state_next;
            used_map_reg   <= used_map_next;
            free_pages_reg <= free_pages_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg       <= need_next;
        scan_reg       <= scan_next;
        got_reg        <= got_next;
        prev_reg       <= prev_next;
        first_reg      <= first_next;
        cur_reg        <= cur_next;
        walk_first_reg <= walk_first_next;
        steps_reg      <= steps_next;
        cnt_reg        <= cnt_next;
        res_reg        <= res_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        used_map_next   = used_map_reg;
        free_pages_next = free_pages_reg;
        need_next       = need_reg;
        scan_next       = scan_reg;
        got_next        = got_reg;
        prev_next       = prev_reg;
        first_next      = first_reg;
        cur_next        = cur_reg;
        walk_first_next = walk_first_reg;
        steps_next      = steps_reg;
        cnt_next        = cnt_reg;
        res_next        = res_reg;
        mem_req         = '0;
        free_sum        = (LINK_W + 1)'(free_pages_reg) + (LINK_W + 1)'(cnt_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    res_next = '{status: ST_OK, result_address: '0, page_count: '0};
                    if (req.req_type == REQ_ALLOC)
                    begin
                        if (req.size_bytes == '0)
                        begin
                            res_next.status = ST_ZERO;
                            state_next      = S_FINISH;
                        end
                        else if ((NEED_W + LINK_W)'(need) >
                                 (NEED_W + LINK_W)'(free_pages_reg))
                        begin
                            res_next.status = ST_NOSPACE;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            need_next  = need;
                            scan_next  = '0;
                            got_next   = '0;
                            state_next = S_ALLOC;
                        end
                    end
                    else
                    begin
                        if (addr_bad)
                        begin
                            res_next.status = ST_BADADDR;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            cur_next        = LINK_W'(offset[PAGE_SHIFT+IDX_W-1:PAGE_SHIFT]);
                            walk_first_next = 1'b1;
                            steps_next      = '0;
                            cnt_next        = '0;
                            state_next      = S_WALK;
                        end
                    end
                end
            end

            S_ALLOC:
            begin
                if ((NEED_W + LINK_W)'(got_reg) == (NEED_W + LINK_W)'(need_reg) ||
                    scan_reg == LINK_END)
                begin
                    // close the chain at the last claimed page
                    mem_req.we      = 1'b1;
                    mem_req.waddr   = prev_reg;
                    mem_req.wdata   = LINK_END;
                    free_pages_next = free_pages_reg - got_reg;
                    res_next.status = ST_OK;
                    res_next.result_address =
                        base_address + (ADDR_W'(first_reg) << PAGE_SHIFT);
                    res_next.page_count = PAGE_COUNT_W'(got_reg);
                    state_next = S_FINISH;
                end
                else
                begin
                    if (!used_map_reg[scan_reg[IDX_W-1:0]])
                    begin
                        used_map_next[scan_reg[IDX_W-1:0]] = 1'b1;
                        if (got_reg != '0)
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = prev_reg;
                            mem_req.wdata = scan_reg;
                        end
                        else
                        begin
                            first_next = scan_reg[IDX_W-1:0];
                        end
                        prev_next = scan_reg[IDX_W-1:0];
                        got_next  = got_reg + LINK_W'(1);
                    end
                    scan_next = scan_reg + LINK_W'(1);
                end
            end

            S_WALK:
            begin
                if (steps_reg == LINK_W'(NUM_PAGES) || cur >= LINK_END)
                begin
                    if (free_sum > (LINK_W + 1)'(NUM_PAGES))
                    begin
                        free_pages_next = LINK_END;
                    end
                    else
                    begin
                        free_pages_next = free_sum[LINK_W-1:0];
                    end
                    res_next.status         = ST_OK;
                    res_next.result_address = '0;
                    res_next.page_count     = PAGE_COUNT_W'(cnt_reg);
                    state_next              = S_FINISH;
                end
                else
                begin
                    if (used_map_reg[cur[IDX_W-1:0]])
                    begin
                        used_map_next[cur[IDX_W-1:0]] = 1'b0;
                        cnt_next = cnt_reg + LINK_W'(1);
                    end
                    mem_req.re      = 1'b1;
                    mem_req.raddr   = cur[IDX_W-1:0];
                    steps_next      = steps_reg + LINK_W'(1);
                    walk_first_next = 1'b0;
                end
            end

            S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_free_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
        (free_pages_reg == LINK_W'(NUM_PAGES - $countones(used_map_reg))))
        else $error("free page count disagrees with used map");

    a_mem_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re))
        else $error("chain memory read and write in the same cycle");

    a_alloc_not_over_need: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC) |-> (32'(got_reg) <= 32'(need_reg)))
        else $error("allocation claimed more pages than requested");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !res_ready) |=>
        (state_reg == S_FINISH && $stable(res_reg)))
        else $error("pending result lost before hand-off");
`endif

endmodule

// File: rtl/bitmap_page_allocator.sv
// Page allocator over a used-page bitmap of bpa_pkg::NUM_PAGES pages of
// bpa_pkg::PAGE_BYTES bytes each, page zero at base_address. An allocate
// transaction rounds size_bytes up to whole pages, claims the lowest-numbered
// free pages (not necessarily contiguous), links them into a chain and returns
// the first page's address; a free transaction takes such an address (or any
// page inside an allocation) and releases that page and the rest of its chain.
// One transaction is in work at a time. Allocate scans one page a cycle and
// writes one link a cycle into the chain memory. Free follows one link a
// cycle through the chain memory's registered read. Zero size, shortage and
// bad address go straight to the result. A finished result sits in an output
// register, so the next request is taken while the result waits; the
// following result then waits until that register empties. No clearing pass
// is needed after reset: the chain memory is only read at entries written by
// an earlier allocation. Write base_address only while no transaction is open.
module bitmap_page_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bpa_pkg::ADDR_W-1:0]    cfg_wdata,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  bpa_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output bpa_pkg::rsp_t                 rsp
);
    import bpa_pkg::*;

    logic [ADDR_W-1:0] base_address_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    logic              res_valid;
    logic              res_ready;
    rsp_t              res;
    mem_req_t          mem_req;
    logic [LINK_W-1:0] mem_rdata;

    // Configuration: one register, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
        end
        else if (cfg_we)
        begin
            base_address_reg <= cfg_wdata;
        end
    end

    // Output register: take a new result whenever the slot is empty or drains
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    bpa_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req          (req),
        .base_address (base_address_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata)
    );

    // Chain links, one entry per page
    bpa_chain_mem u_chain_mem (
        .clk       (clk),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

endmodule
